### rtl/lnr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lnr_pkg
// Shared constants, codes and types of the layer/RMS normalization row unit.
// ----------------------------------------------------------------------------
package lnr_pkg;

   localparam int MAX_DIM  = 64;
   localparam int ADDR_W   = $clog2(MAX_DIM);
   localparam int CNT_W    = ADDR_W + 1;
   localparam int X_W      = 16;
   localparam int WORD_W   = 3 * X_W;
   localparam int SUM_W    = 24;
   localparam int SQR_W    = 31;
   localparam int SQ_W     = 37;
   localparam int NUM_W    = 43;
   localparam int DEN_W    = 13;
   localparam int REM_W    = DEN_W;
   localparam int T_W      = 32;
   localparam int R_W      = 37;
   localparam int R_LO_W   = 19;
   localparam int R_HI_W   = R_W - R_LO_W;
   localparam int A_W      = 39;
   localparam int PROD_W   = 76;
   localparam int P_W      = 40;
   localparam int V_W      = 42;
   localparam int RA_W     = 73;
   localparam int RS_W     = 107;
   localparam int EPS_W    = 24;
   localparam int CSR_IDX_W = 1;

   localparam logic [EPS_W-1:0]     EPS_RESET   = 24'd168;
   localparam logic [CSR_IDX_W-1:0] CSR_RMS_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON  = 1'd1;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_SQ,
      ST_DRAIN,
      ST_STAT_MUL,
      ST_STAT_SUB,
      ST_DIV_STAT,
      ST_DIV_WAIT,
      ST_RSQ_START,
      ST_RSQ_WAIT,
      ST_E_READ,
      ST_E_MULN,
      ST_E_CENT,
      ST_E_MULA,
      ST_E_MULR0,
      ST_E_MULR1,
      ST_E_SUM,
      ST_E_DIV,
      ST_E_DIVW,
      ST_E_OUT
   } lnr_state_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_SQ_READ,
      OP_STAT_MUL,
      OP_STAT_SUB,
      OP_DIV_STAT,
      OP_RSQ_START,
      OP_ELEM_READ,
      OP_ELEM_MULN,
      OP_ELEM_CENT,
      OP_ELEM_MULA,
      OP_ELEM_MULR0,
      OP_ELEM_MULR1,
      OP_ELEM_SUM,
      OP_DIV_ELEM,
      OP_ELEM_OUT
   } lnr_op_type;

   typedef struct packed {
      lnr_op_type        op;
      logic [ADDR_W-1:0] idx;
      logic              last;
   } lnr_cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] cnt;
      logic             rms;
      logic             div_done;
      logic             rsq_done;
      logic             out_free;
   } lnr_stat_type;

endpackage
`default_nettype wire

### rtl/layer_norm_row_unit_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// layer_norm_row_unit_top
// Layer / RMS normalization of one row of up to 64 Q4.12 elements.
// ----------------------------------------------------------------------------
// Elements load at one per cycle while the unit is in its load phase; the
// transfer with tlast closes the row, and items past 64 are dropped. After
// the row closes the unit accepts nothing until the row's last result has
// been handed to the output register: a sum-of-squares pass over the store,
// the statistic and its divide, a reciprocal square root, then the element
// steps, where standard mode adds a divide by n in the one-bit-per-cycle
// divider; an output stall holds them until the result is taken.
// Results saturate to 16 bits with tuser flagging it.
module layer_norm_row_unit_top
   import lnr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [WORD_W-1:0]    req_tdata,   // sample, gain, shift
   input  wire logic                 req_tlast,   // row_end
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic      [X_W-1:0]       rsp_tdata,   // normalized
   output logic                      rsp_tuser,   // clipped
   output logic                      rsp_tlast,   // final_res
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [EPS_W-1:0]     csr_wdata
);

   lnr_cmd_type  cmd;
   lnr_stat_type sts;

   assign csr_ready = 1'b1;

   lnr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lnr_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

### rtl/lnr_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lnr_div
// Restoring divider, one quotient bit per cycle, pulses done when finished.
// ----------------------------------------------------------------------------
module lnr_div
   import lnr_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic      [NUM_W-1:0] quo
);

   localparam logic [5:0] LAST_STEP = 6'(NUM_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [5:0]       step_ff, step_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [REM_W:0]   trial;
   logic             ge;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = LAST_STEP;
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in  = ge ? REM_W'(trial - {1'b0, den_ff}) : trial[REM_W-1:0];
         quo_in  = {quo_ff[NUM_W-2:0], ge};
         step_in = step_ff - 6'd1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule
`default_nettype wire

### rtl/lnr_rsqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lnr_rsqrt
// Bit-serial floor(2^36 / sqrt(t)): largest r with r*r*t <= 2^72.
// ----------------------------------------------------------------------------
module lnr_rsqrt
   import lnr_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [T_W-1:0] t,
   output logic                done,
   output logic      [R_W-1:0] r
);

   // a_ff = r*r*t, bs_ff = r*t*2^(b+1), ts_ff = t*2^(2b) for current bit b
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [5:0]      bit_ff, bit_in;
   logic [RA_W-1:0] a_ff, a_in;
   logic [RS_W-1:0] bs_ff, bs_in;
   logic [RS_W-1:0] ts_ff, ts_in;
   logic [R_W-1:0]  r_ff, r_in;
   logic [RS_W-1:0] test;
   logic            fit;

   assign test = RS_W'(a_ff) + bs_ff + ts_ff;
   assign fit  = (test[RS_W-1:RA_W] == '0) &&
                 (!test[RA_W-1] || (test[RA_W-2:0] == '0));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      bit_in  = bit_ff;
      a_in    = a_ff;
      bs_in   = bs_ff;
      ts_in   = ts_ff;
      r_in    = r_ff;
      if (start) begin
         busy_in = 1'b1;
         bit_in  = 6'(R_W - 1);
         a_in    = '0;
         bs_in   = '0;
         ts_in   = {3'b000, t, 72'd0};
         r_in    = '0;
      end else if (busy_ff) begin
         if (fit) begin
            a_in = test[RA_W-1:0];
            r_in = r_ff | (R_W'(1) << bit_ff);
         end
         bs_in = (bs_ff >> 1) + (fit ? ts_ff : '0);
         ts_in = ts_ff >> 2;
         bit_in = bit_ff - 6'd1;
         if (bit_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         bit_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         bit_ff  <= bit_in;
      end
      a_ff  <= a_in;
      bs_ff <= bs_in;
      ts_ff <= ts_in;
      r_ff  <= r_in;
   end

   assign done = done_ff;
   assign r    = r_ff;

endmodule
`default_nettype wire

### rtl/lnr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lnr_ctrl
// Sequencer: row load, statistics pass, reciprocal root, element emission.
// ----------------------------------------------------------------------------
module lnr_ctrl
   import lnr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tlast,
   output logic              req_tready,
   input  wire lnr_stat_type sts,
   output lnr_cmd_type       cmd
);

   lnr_state_type     state_ff, state_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic              drain_ff, drain_in;
   logic              at_last;

   assign at_last = {1'b0, idx_ff} == (sts.cnt - CNT_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      drain_in = drain_ff;
      unique case (state_ff)
         ST_LOAD: begin
            idx_in = '0;
            if (req_tvalid && req_tlast) state_in = ST_SQ;
         end
         ST_SQ: begin
            idx_in = idx_ff + ADDR_W'(1);
            if (at_last) begin
               state_in = ST_DRAIN;
               drain_in = 1'b0;
            end
         end
         ST_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) state_in = ST_STAT_MUL;
         end
         ST_STAT_MUL:  state_in = ST_STAT_SUB;
         ST_STAT_SUB:  state_in = ST_DIV_STAT;
         ST_DIV_STAT:  state_in = ST_DIV_WAIT;
         ST_DIV_WAIT:  if (sts.div_done) state_in = ST_RSQ_START;
         ST_RSQ_START: state_in = ST_RSQ_WAIT;
         ST_RSQ_WAIT: begin
            idx_in = '0;
            if (sts.rsq_done) state_in = ST_E_READ;
         end
         ST_E_READ:  state_in = ST_E_MULN;
         ST_E_MULN:  state_in = ST_E_CENT;
         ST_E_CENT:  state_in = ST_E_MULA;
         ST_E_MULA:  state_in = ST_E_MULR0;
         ST_E_MULR0: state_in = ST_E_MULR1;
         ST_E_MULR1: state_in = ST_E_SUM;
         ST_E_SUM:   state_in = sts.rms ? ST_E_OUT : ST_E_DIV;
         ST_E_DIV:   state_in = ST_E_DIVW;
         ST_E_DIVW:  if (sts.div_done) state_in = ST_E_OUT;
         ST_E_OUT: begin
            if (sts.out_free) begin
               idx_in   = idx_ff + ADDR_W'(1);
               state_in = at_last ? ST_LOAD : ST_E_READ;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      cmd.op     = OP_IDLE;
      cmd.idx    = idx_ff;
      cmd.last   = at_last;
      unique case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            cmd.op     = OP_LOAD;
         end
         ST_SQ:        cmd.op = OP_SQ_READ;
         ST_STAT_MUL:  cmd.op = OP_STAT_MUL;
         ST_STAT_SUB:  cmd.op = OP_STAT_SUB;
         ST_DIV_STAT:  cmd.op = OP_DIV_STAT;
         ST_RSQ_START: cmd.op = OP_RSQ_START;
         ST_E_READ:    cmd.op = OP_ELEM_READ;
         ST_E_MULN:    cmd.op = OP_ELEM_MULN;
         ST_E_CENT:    cmd.op = OP_ELEM_CENT;
         ST_E_MULA:    cmd.op = OP_ELEM_MULA;
         ST_E_MULR0:   cmd.op = OP_ELEM_MULR0;
         ST_E_MULR1:   cmd.op = OP_ELEM_MULR1;
         ST_E_SUM:     cmd.op = OP_ELEM_SUM;
         ST_E_DIV:     cmd.op = OP_DIV_ELEM;
         ST_E_OUT:     if (sts.out_free) cmd.op = OP_ELEM_OUT;
         default:      cmd.op = OP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         idx_ff   <= '0;
         drain_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         drain_ff <= drain_in;
      end
   end

endmodule
`default_nettype wire

### rtl/lnr_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lnr_dp
// Datapath: row store, sums, statistic, divider and root units, output stage.
// ----------------------------------------------------------------------------
module lnr_dp
   import lnr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lnr_cmd_type          cmd,
   output lnr_stat_type              sts,
   input  wire logic                 req_tvalid,
   input  wire logic [WORD_W-1:0]    req_tdata,
   input  wire logic                 csr_valid,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [EPS_W-1:0]     csr_wdata,
   input  wire logic                 rsp_tready,
   output logic                      rsp_tvalid,
   output logic      [X_W-1:0]       rsp_tdata,
   output logic                      rsp_tuser,
   output logic                      rsp_tlast
);

   logic [WORD_W-1:0] store_mem [MAX_DIM];

   logic                    rms_ff;
   logic [EPS_W-1:0]        eps_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [SQ_W-1:0]         acc_ff;
   logic [WORD_W-1:0]       rd_ff;
   logic                    rd_vld_ff;
   logic [SQR_W-1:0]        sqr_ff;
   logic                    sqr_vld_ff;
   logic [NUM_W-1:0]        nq_ff, ss_ff, num_ff;
   logic [DEN_W-1:0]        den_ff;
   logic signed [SUM_W-1:0] nx_ff;
   logic [22:0]             cabs_ff;
   logic                    cneg_ff;
   logic [X_W-1:0]          gabs_ff;
   logic                    gneg_ff;
   logic [A_W-1:0]          a_ff;
   logic                    neg_ff;
   logic [A_W+R_LO_W-1:0]   pplo_ff;
   logic [A_W+R_HI_W-1:0]   pphi_ff;
   logic [P_W-1:0]          p_ff;
   logic                    out_vld_ff;
   logic [X_W-1:0]          out_data_ff;
   logic                    out_clip_ff;
   logic                    out_last_ff;

   logic signed [X_W-1:0]   rd_x, rd_g, rd_s;
   logic signed [X_W-1:0]   in_x;
   logic signed [2*X_W-1:0] sq_full;
   logic [SUM_W-1:0]        sum_abs;
   logic signed [SUM_W-1:0] cent;
   logic [SUM_W-1:0]        cent_abs;
   logic [X_W:0]            g_abs;
   logic [PROD_W-1:0]       prod;
   logic                    div_start, div_done;
   logic [NUM_W-1:0]        div_num, div_quo;
   logic [DEN_W-1:0]        div_den;
   logic                    rsq_start, rsq_done;
   logic [T_W-1:0]          rsq_t;
   logic [R_W-1:0]          r;
   logic [P_W-1:0]          q;
   logic signed [V_W-1:0]   qs, vq, v;
   logic                    out_free;
   logic                    load;

   assign rd_x = rd_ff[X_W-1:0];
   assign rd_g = rd_ff[2*X_W-1:X_W];
   assign rd_s = rd_ff[3*X_W-1:2*X_W];
   assign in_x = req_tdata[X_W-1:0];
   assign load = (cmd.op == OP_LOAD) && req_tvalid;

   assign sq_full  = rd_x * rd_x;
   assign sum_abs  = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign cent     = rms_ff ? SUM_W'(rd_x) : SUM_W'(nx_ff - sum_ff);
   assign cent_abs = cent[SUM_W-1] ? SUM_W'(-cent) : SUM_W'(cent);
   assign g_abs    = rd_g[X_W-1] ? (X_W+1)'(-$signed({rd_g[X_W-1], rd_g}))
                                 : (X_W+1)'({1'b0, rd_g});
   assign prod     = PROD_W'(pplo_ff) + (PROD_W'(pphi_ff) << R_LO_W);

   assign div_start = (cmd.op == OP_DIV_STAT) || (cmd.op == OP_DIV_ELEM);
   assign div_num   = (cmd.op == OP_DIV_STAT) ? num_ff : NUM_W'(p_ff);
   assign div_den   = (cmd.op == OP_DIV_STAT) ? den_ff : DEN_W'(cnt_ff);
   assign rsq_start = cmd.op == OP_RSQ_START;
   assign rsq_t     = div_quo[T_W-1:0] + T_W'(eps_ff);

   lnr_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   lnr_rsqrt u_rsqrt (
      .clock (clock),
      .reset (reset),
      .start (rsq_start),
      .t     (rsq_t),
      .done  (rsq_done),
      .r     (r)
   );

   // signed result, plus the offset in standard mode, then saturate
   assign q  = rms_ff ? p_ff : div_quo[P_W-1:0];
   assign qs = $signed({2'b00, q});
   assign vq = neg_ff ? -qs : qs;
   assign v  = rms_ff ? vq : vq + V_W'(rd_s);

   assign out_free = !out_vld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (load && !cnt_ff[ADDR_W]) begin
         store_mem[cnt_ff[ADDR_W-1:0]] <= req_tdata;
      end
      if ((cmd.op == OP_SQ_READ) || (cmd.op == OP_ELEM_READ)) begin
         rd_ff <= store_mem[cmd.idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rms_ff     <= 1'b0;
         eps_ff     <= EPS_RESET;
         cnt_ff     <= '0;
         sum_ff     <= '0;
         acc_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         sqr_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_RMS_MODE: rms_ff <= csr_wdata[0];
               CSR_EPSILON:  eps_ff <= csr_wdata;
               default:      ;
            endcase
         end
         // drop items beyond the store depth
         if (load && !cnt_ff[ADDR_W]) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            sum_ff <= sum_ff + SUM_W'(in_x);
         end
         rd_vld_ff  <= cmd.op == OP_SQ_READ;
         sqr_vld_ff <= rd_vld_ff;
         if (sqr_vld_ff) acc_ff <= acc_ff + SQ_W'(sqr_ff);
         if (rsp_tready) out_vld_ff <= 1'b0;
         if (cmd.op == OP_ELEM_OUT) begin
            out_vld_ff <= 1'b1;
            if (cmd.last) begin
               cnt_ff <= '0;
               sum_ff <= '0;
               acc_ff <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_vld_ff) sqr_ff <= sq_full[SQR_W-1:0];
      unique case (cmd.op)
         OP_STAT_MUL: begin
            nq_ff <= NUM_W'(cnt_ff * acc_ff);
            ss_ff <= NUM_W'(sum_abs[21:0] * sum_abs[21:0]);
         end
         OP_STAT_SUB: begin
            num_ff <= rms_ff ? NUM_W'(acc_ff) : NUM_W'(nq_ff - ss_ff);
            den_ff <= rms_ff ? DEN_W'(cnt_ff) : DEN_W'(cnt_ff * cnt_ff);
         end
         OP_ELEM_MULN: nx_ff <= SUM_W'($signed({1'b0, cnt_ff}) * rd_x);
         OP_ELEM_CENT: begin
            cabs_ff <= cent_abs[22:0];
            cneg_ff <= cent[SUM_W-1];
            gabs_ff <= g_abs[X_W-1:0] | {g_abs[X_W], {(X_W-1){1'b0}}};
            gneg_ff <= rd_g[X_W-1];
         end
         OP_ELEM_MULA: begin
            a_ff   <= A_W'(gabs_ff * cabs_ff);
            neg_ff <= gneg_ff ^ cneg_ff;
         end
         OP_ELEM_MULR0: pplo_ff <= a_ff * r[R_LO_W-1:0];
         OP_ELEM_MULR1: pphi_ff <= a_ff * r[R_W-1:R_LO_W];
         OP_ELEM_SUM:   p_ff    <= prod[PROD_W-1:36];
         OP_ELEM_OUT: begin
            out_last_ff <= cmd.last;
            if (v > V_W'(32767)) begin
               out_data_ff <= 16'h7FFF;
               out_clip_ff <= 1'b1;
            end else if (v < -V_W'(32768)) begin
               out_data_ff <= 16'h8000;
               out_clip_ff <= 1'b1;
            end else begin
               out_data_ff <= v[X_W-1:0];
               out_clip_ff <= 1'b0;
            end
         end
         default: ;
      endcase
   end

   assign sts.cnt      = cnt_ff;
   assign sts.rms      = rms_ff;
   assign sts.div_done = div_done;
   assign sts.rsq_done = rsq_done;
   assign sts.out_free = out_free;

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_clip_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the layer/RMS normalization row unit: rows of
// directed and random elements are streamed in under several mode and epsilon
// settings; each result is checked against an integer model or a typed value.
// ----------------------------------------------------------------------------
module tb_top;
   import lnr_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;

   typedef struct {
      logic [15:0] val;
      logic        clip;
      logic        fin;
   } norm_result_type;

   typedef struct {
      logic [15:0] sample;
      logic [15:0] gain;
      logic [15:0] shift;
      logic        row_end;
      bit          typed;      // expected value below holds for this row end
      logic [15:0] exp_val;
      logic        exp_clip;
   } stim_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [WORD_W-1:0]    req_tdata;
   logic                 req_tlast;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [X_W-1:0]       rsp_tdata;
   logic                 rsp_tuser;
   logic                 rsp_tlast;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [EPS_W-1:0]     csr_wdata;

   // model state
   logic              mdl_rms;
   logic [EPS_W-1:0]  mdl_eps;
   logic signed [15:0] row_x [MAX_DIM];
   logic signed [15:0] row_g [MAX_DIM];
   logic signed [15:0] row_b [MAX_DIM];
   int                row_len;
   longint            row_sum;

   norm_result_type   expected_q[$];
   int                errors;
   int                cycles;
   int                rows_closed;
   int                results_seen;
   int                clips_seen;
   int                items_sent;
   int                stall_left;
   bit                no_gaps;

   layer_norm_row_unit_top i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [36:0] rsqrt_q24(input logic [31:0] t);
      logic [127:0] r;
      logic [127:0] cand;
      r = '0;
      for (int b = 36; b >= 0; b--) begin
         cand = r | (128'd1 << b);
         if (cand * cand * t <= (128'd1 << 72)) r = cand;
      end
      return r[36:0];
   endfunction

   // close the row: compute statistics and queue one result per element
   task automatic close_row(input bit typed, input logic [15:0] tv, input logic tc);
      longint unsigned sq;
      longint unsigned stat;
      longint unsigned as;
      logic [36:0]     r;
      longint          c;
      longint          g;
      longint          v;
      logic [127:0]    prod;
      longint unsigned q;
      norm_result_type res;
      sq = 0;
      for (int j = 0; j < row_len; j++) sq += longint'(row_x[j]) * longint'(row_x[j]);
      as = (row_sum < 0) ? -row_sum : row_sum;
      if (mdl_rms) stat = sq / row_len;
      else stat = (longint'(row_len) * sq - as * as) / (longint'(row_len) * row_len);
      r = rsqrt_q24(32'(stat + mdl_eps));
      for (int j = 0; j < row_len; j++) begin
         g = row_g[j];
         c = mdl_rms ? longint'(row_x[j]) : longint'(row_len) * row_x[j] - row_sum;
         prod = 128'((g < 0) ? -g : g) * 128'((c < 0) ? -c : c) * 128'(r);
         q = 64'(prod >> 36) / (mdl_rms ? 1 : row_len);
         v = ((g < 0) != (c < 0)) ? -longint'(q) : longint'(q);
         if (!mdl_rms) v += row_b[j];
         res.clip = 1'b0;
         if (v > 32767) begin
            v = 32767;
            res.clip = 1'b1;
         end
         if (v < -32768) begin
            v = -32768;
            res.clip = 1'b1;
         end
         res.val = v[15:0];
         res.fin = (j + 1 == row_len);
         if (typed && res.fin) begin
            res.val  = tv;
            res.clip = tc;
         end
         expected_q.push_back(res);
      end
      row_len = 0;
      row_sum = 0;
      rows_closed++;
   endtask

   task automatic store_element(input stim_row_type it);
      if (row_len < MAX_DIM) begin
         row_x[row_len] = it.sample;
         row_g[row_len] = it.gain;
         row_b[row_len] = it.shift;
         row_sum += $signed(it.sample);
         row_len++;
      end
      if (it.row_end) close_row(it.typed, it.exp_val, it.exp_clip);
   endtask

   task automatic send_element(input stim_row_type it);
      int gap;
      gap = 0;
      if (!no_gaps) begin
         if ($urandom_range(0, 19) == 0) gap = $urandom_range(10, 40);
         else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {it.shift, it.gain, it.sample};
      req_tlast  <= it.row_end;
      do @(posedge clock); while (!req_tready);
      store_element(it);
      items_sent++;
   endtask

   task automatic end_stream;
      req_tvalid <= 1'b0;
      wait (expected_q.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [EPS_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_RMS_MODE) mdl_rms = val[0];
      else mdl_eps = val;
      @(posedge clock);
   endtask

   function automatic logic [15:0] rand_value();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'(16'sd4096);
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic send_random_row(input int len);
      stim_row_type it;
      it.typed = 0;
      it.exp_val = '0;
      it.exp_clip = 1'b0;
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++) begin
         it.sample  = rand_value();
         it.gain    = rand_value();
         it.shift   = rand_value();
         it.row_end = (k == len - 1);
         send_element(it);
      end
   endtask

   // result sink with random back-pressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 29) == 0) begin
         stall_left <= $urandom_range(10, 40);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      norm_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (rsp_tuser) clips_seen++;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result %h clip %b last %b", $realtime,
                     rsp_tdata, rsp_tuser, rsp_tlast);
            errors++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_tdata !== want.val) begin
               $display("%0t: normalized expected %h actual %h", $realtime, want.val, rsp_tdata);
               errors++;
            end
            if (rsp_tuser !== want.clip) begin
               $display("%0t: clipped expected %b actual %b", $realtime, want.clip, rsp_tuser);
               errors++;
            end
            if (rsp_tlast !== want.fin) begin
               $display("%0t: final expected %b actual %b", $realtime, want.fin, rsp_tlast);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("layer_norm_row_unit_top verification failed");
         $finish;
      end
   end

   initial begin
      stim_row_type directed[$];
      int budget;
      int row_n;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_RMS_MODE;
      csr_wdata = '0;
      errors = 0;
      cycles = 0;
      rows_closed = 0;
      results_seen = 0;
      clips_seen = 0;
      items_sent = 0;
      stall_left = 0;
      no_gaps = 0;
      mdl_rms = 1'b0;
      mdl_eps = EPS_RESET;
      row_len = 0;
      row_sum = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sample, gain, shift, row_end, typed, expected, clip
      // single-element rows center to zero, so the result is the shift
      directed = '{
         '{16'h1234, 16'h7FFF, 16'h0ABC, 1, 1, 16'h0ABC, 0},
         '{16'h8000, 16'h8000, 16'h8000, 1, 1, 16'h8000, 0},
         '{16'h7FFF, 16'h1000, 16'h7FFF, 1, 1, 16'h7FFF, 0},
         '{16'h8000, 16'h7FFF, 16'h0000, 0, 0, 16'h0, 0},
         '{16'h7FFF, 16'h7FFF, 16'h7FFF, 1, 0, 16'h0, 0},
         '{16'h0000, 16'h8000, 16'h0000, 0, 0, 16'h0, 0},
         '{16'hF000, 16'h1000, 16'h0100, 0, 0, 16'h0, 0},
         '{16'h1000, 16'h1000, 16'hFF00, 0, 0, 16'h0, 0},
         '{16'h2000, 16'hF000, 16'h8000, 1, 0, 16'h0, 0},
         '{16'h0555, 16'h1000, 16'h0000, 0, 0, 16'h0, 0},
         '{16'h0555, 16'h1000, 16'h0321, 1, 1, 16'h0321, 0}
      };
      foreach (directed[k]) send_element(directed[k]);
      end_stream();

      // RMS mode with zero epsilon: all-zero row takes the all-ones root
      write_csr(CSR_RMS_MODE, 1);
      write_csr(CSR_EPSILON, 0);
      directed = '{
         '{16'h0000, 16'h7FFF, 16'h1111, 0, 0, 16'h0, 0},
         '{16'h0000, 16'h8000, 16'h2222, 1, 1, 16'h0000, 0},
         '{16'h7FFF, 16'h7FFF, 16'h0000, 0, 0, 16'h0, 0},
         '{16'h8000, 16'h8000, 16'h0000, 1, 0, 16'h0, 0},
         '{16'h0001, 16'h7FFF, 16'h0000, 1, 0, 16'h0, 0}
      };
      foreach (directed[k]) send_element(directed[k]);
      end_stream();

      // overflowing row: items past the store are dropped, end still closes
      write_csr(CSR_RMS_MODE, 0);
      write_csr(CSR_EPSILON, 24'hFFFFFF);
      send_random_row(MAX_DIM + 5);
      end_stream();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               write_csr(CSR_RMS_MODE, 0);
               write_csr(CSR_EPSILON, 0);
            end
            1: begin
               write_csr(CSR_RMS_MODE, 1);
               write_csr(CSR_EPSILON, 24'hFFFFFF);
            end
            2: begin
               write_csr(CSR_RMS_MODE, 1);
               write_csr(CSR_EPSILON, 24'($urandom_range(0, 4096)));
            end
            default: begin
               write_csr(CSR_RMS_MODE, 0);
               write_csr(CSR_EPSILON, 24'($urandom()));
            end
         endcase
         budget = 7;
         while (budget > 0) begin
            row_n = $urandom_range(1, 8);
            send_random_row(row_n);
            budget -= row_n;
         end
         end_stream();
      end

      $display("rows closed %0d, elements sent %0d, results checked %0d, clipped %0d",
               rows_closed, items_sent, results_seen, clips_seen);
      $display("covered standard and RMS modes, epsilon extremes, full and overflowing rows");
      if (errors == 0 && expected_q.size() == 0)
         $display("layer_norm_row_unit_top verification clean");
      else
         $display("layer_norm_row_unit_top verification failed");
      $finish;
   end

endmodule
